FILE: rtl/pidfd_pkg.sv
// Package: shared types, codes and saturation helpers for the PID core.
`default_nettype none
package pidfd_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_GAIN_P  = 3'd0;
  localparam logic [2:0] REG_GAIN_I  = 3'd1;
  localparam logic [2:0] REG_GAIN_D  = 3'd2;
  localparam logic [2:0] REG_INT_BND = 3'd3;
  localparam logic [2:0] REG_OUT_BND = 3'd4;
  localparam logic [2:0] REG_ALPHA   = 3'd5;

  // Input function codes.
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  localparam logic [16:0] ALPHA_ONE = 17'd65536;
  localparam logic signed [47:0] LIM48_POS = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] LIM48_NEG = 48'sh8000_0000_0000;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_P, ST_MUL_I, ST_MUL_IT, ST_DIV,
    ST_MUL_F, ST_MUL_D, ST_SUM, ST_DONE
  } seq_state_t;

  // Request to the serial multiplier.
  typedef struct packed {
    logic go;
    logic shift_long;  // scale down by 2^24 instead of 2^16
  } mul_req_t;

  // Saturate a 50-bit signed value to 48 bits.
  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > 50'sh0_7FFF_FFFF_FFFF) begin
      r = LIM48_POS;
    end else if (v < -50'sh0_8000_0000_0000) begin
      r = LIM48_NEG;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  // Clamp a signed value to plus or minus a bound; a zero bound disables it.
  function automatic logic signed [49:0] clamp_mag(input logic signed [49:0] v,
                                                   input logic [30:0] bound);
    logic signed [49:0] b;
    logic signed [49:0] r;
    b = $signed({19'd0, bound});
    r = v;
    if (bound != 31'd0) begin
      if (v > b) begin
        r = b;
      end else if (v < -b) begin
        r = -b;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/pidfd_mul.sv
// Serial shift-add multiplier: one multiplier bit per cycle, scaled and saturated to 48 bits.
`default_nettype none
module pidfd_mul (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pidfd_pkg::mul_req_t   req,
  input  wire logic signed [47:0]    op_a,
  input  wire logic signed [32:0]    op_b,
  output logic                       done,
  output logic signed [47:0]         product
);

  logic        busy_r, busy_nxt;
  logic        fin_r, fin_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [79:0] prod_r, prod_nxt;
  logic [47:0] a_r, a_nxt;
  logic        neg_r, neg_nxt;
  logic        long_r, long_nxt;
  logic signed [47:0] res_r, res_nxt;
  logic        done_r, done_nxt;

  logic [47:0] a_mag;
  logic [32:0] b_mag;
  logic [48:0] part_sum;
  logic        ovf;

  // Magnitudes of the operands at launch.
  assign a_mag = op_a[47] ? 48'(-op_a) : 48'(op_a);
  assign b_mag = op_b[32] ? 33'(-op_b) : 33'(op_b);

  // One partial-product add per cycle into the upper half.
  assign part_sum = {1'b0, prod_r[79:32]} + (prod_r[0] ? {1'b0, a_r} : 49'd0);

  // Scale down and detect overflow of the 48-bit result.
  always_comb begin
    logic [63:0] m;
    m = long_r ? 64'(prod_r >> 24) : 64'(prod_r >> 16);
    if (neg_r) begin
      ovf = (m > 64'h0000_8000_0000_0000);
    end else begin
      ovf = (m > 64'h0000_7FFF_FFFF_FFFF);
    end
    if (neg_r) begin
      res_nxt = ovf ? pidfd_pkg::LIM48_NEG : -$signed(m[47:0]);
    end else begin
      res_nxt = ovf ? pidfd_pkg::LIM48_POS : $signed(m[47:0]);
    end
    if (!fin_r) begin
      res_nxt = res_r;
    end
  end

  // Sequencing of the shift-add steps.
  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    a_nxt    = a_r;
    neg_nxt  = neg_r;
    long_nxt = long_r;
    done_nxt = fin_r;
    if (req.go && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      prod_nxt = {48'd0, b_mag[31:0]};
      a_nxt    = a_mag;
      neg_nxt  = op_a[47] ^ op_b[32];
      long_nxt = req.shift_long;
    end else if (busy_r) begin
      prod_nxt = {part_sum, prod_r[31:1]};
      cnt_nxt  = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    prod_r <= prod_nxt;
    a_r    <= a_nxt;
    neg_r  <= neg_nxt;
    long_r <= long_nxt;
    res_r  <= res_nxt;
  end

  assign done    = done_r;
  assign product = res_r;

endmodule
`default_nettype wire

FILE: rtl/pidfd_div.sv
// Restoring divider, one quotient bit per cycle, for the measurement rate.
`default_nettype none
module pidfd_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire logic signed [32:0] diff,
  input  wire logic [31:0]        divisor,
  output logic                    done,
  output logic signed [47:0]      rate
);

  logic        busy_r, busy_nxt;
  logic        fin_r, fin_nxt;
  logic        done_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [56:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        neg_r, neg_nxt;
  logic signed [47:0] res_r, res_nxt;
  logic [32:0] diff_mag;
  logic [32:0] rem_sh;
  logic [33:0] trial;

  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign rem_sh   = {rem_r, quo_r[56]};
  assign trial    = {1'b0, rem_sh} - {2'b00, dvs_r};

  // Step control and quotient bits.
  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (go && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      quo_nxt  = {diff_mag, 24'd0};
      rem_nxt  = 32'd0;
      dvs_nxt  = divisor;
      neg_nxt  = diff[32];
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[55:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[31:0];
        quo_nxt = {quo_r[55:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd56) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  // Saturate the signed quotient to 48 bits.
  always_comb begin
    res_nxt = res_r;
    if (fin_r) begin
      if (neg_r) begin
        res_nxt = (quo_r >= 57'h0_8000_0000_0000) ? pidfd_pkg::LIM48_NEG
                                                  : -$signed(quo_r[47:0]);
      end else begin
        res_nxt = (quo_r > 57'h0_7FFF_FFFF_FFFF) ? pidfd_pkg::LIM48_POS
                                                 : $signed(quo_r[47:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= fin_r;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign rate = res_r;

endmodule
`default_nettype wire

FILE: rtl/pid_controller_filtered_derivative_core.sv
// Top level: PID controller with filtered derivative on measurement.
//
// Input beats carry target, sensed and step_time in in_tdata and the function
// (update or clear) in in_tuser. Each beat gives exactly one output beat with
// the Q16.16 drive value. Gains, bounds and the filter coefficient are to be
// written through the cfg_ channel while the core is idle; the user keeps to
// this, the core leaves it unchecked. cfg_ready is always high. One item is
// processed at a time. A clear beat or a zero step time skips to the done
// state. A control update runs five products on the shared serial multiplier
// (one multiplier bit a cycle) and one 57-step restoring division for the rate,
// plus a summing state. The next input beat is taken as soon as the result sits
// in the output register, so a stalled receiver holds one result while the next
// item runs; a second result then waits until out_tready frees the register.
// Synchronous reset clears the configuration to its defaults (filter
// coefficient one, all else zero), the integral, filtered rate and last
// measurement, and empties the output register.
`default_nettype none
module pid_controller_filtered_derivative_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // target[31:0], sensed[63:32], step_time[95:64]
  input  wire logic        in_tuser,   // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // drive[31:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  pidfd_pkg::seq_state_t state_r, state_nxt;
  logic launched_r, launched_nxt;

  logic signed [31:0] gain_p_r, gain_i_r, gain_d_r;
  logic [30:0] int_bnd_r, out_bnd_r;
  logic [16:0] alpha_r;

  logic signed [47:0] integ_r, integ_nxt;
  logic signed [47:0] frate_r, frate_nxt;
  logic signed [31:0] last_r, last_nxt;

  logic signed [32:0] err_r, err_nxt;
  logic signed [32:0] diff_r, diff_nxt;
  logic signed [31:0] sensed_r, sensed_nxt;
  logic [31:0] dt_r, dt_nxt;
  logic signed [47:0] p_r, p_nxt, ip_r, ip_nxt, rate_r, rate_nxt, d_r, d_nxt;
  logic signed [31:0] res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  pidfd_pkg::mul_req_t mreq;
  logic signed [47:0] mul_a;
  logic signed [32:0] mul_b;
  logic mul_done;
  logic signed [47:0] mul_res;
  logic div_go, div_done;
  logic signed [47:0] div_res;

  logic signed [31:0] in_target, in_sensed;
  logic [31:0] in_step;
  logic signed [47:0] fdiff;
  logic [16:0] alpha_eff;
  logic signed [49:0] sum, sum_cl;

  assign in_target = in_tdata[31:0];
  assign in_sensed = in_tdata[63:32];
  assign in_step   = in_tdata[95:64];
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == pidfd_pkg::ST_IDLE);

  // Filter difference, effective coefficient and the output sum.
  assign fdiff = pidfd_pkg::sat48(50'(rate_r) - 50'(frate_r));
  assign alpha_eff = (alpha_r > pidfd_pkg::ALPHA_ONE) ? pidfd_pkg::ALPHA_ONE : alpha_r;
  assign sum = 50'(p_r) + 50'(integ_r) + 50'(d_r);
  assign sum_cl = pidfd_pkg::clamp_mag(sum, out_bnd_r);

  pidfd_mul u_mul (
    .clk(clk), .rst_n(rst_n), .req(mreq), .op_a(mul_a), .op_b(mul_b),
    .done(mul_done), .product(mul_res)
  );

  pidfd_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .diff(diff_r), .divisor(dt_r),
    .done(div_done), .rate(div_res)
  );

  // Sequencer: next state, operand selection and state updates.
  always_comb begin
    logic signed [47:0] isum;
    state_nxt    = state_r;
    launched_nxt = launched_r;
    integ_nxt    = integ_r;
    frate_nxt    = frate_r;
    last_nxt     = last_r;
    err_nxt      = err_r;
    diff_nxt     = diff_r;
    sensed_nxt   = sensed_r;
    dt_nxt       = dt_r;
    p_nxt        = p_r;
    ip_nxt       = ip_r;
    rate_nxt     = rate_r;
    d_nxt        = d_r;
    res_nxt      = res_r;
    mreq.go         = 1'b0;
    mreq.shift_long = 1'b0;
    mul_a        = 48'(err_r);
    mul_b        = 33'(gain_p_r);
    div_go       = 1'b0;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    isum = pidfd_pkg::sat48(50'(integ_r) + 50'(mul_res));

    case (state_r)
      pidfd_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          err_nxt    = 33'(in_target) - 33'(in_sensed);
          diff_nxt   = 33'(last_r) - 33'(in_sensed);
          sensed_nxt = in_sensed;
          dt_nxt     = in_step;
          res_nxt    = 32'sd0;
          if (in_tuser == pidfd_pkg::FUNC_CLEAR) begin
            integ_nxt = 48'sd0;
            frate_nxt = 48'sd0;
            last_nxt  = 32'sd0;
            state_nxt = pidfd_pkg::ST_DONE;
          end else if (in_step == 32'd0) begin
            state_nxt = pidfd_pkg::ST_DONE;
          end else begin
            state_nxt = pidfd_pkg::ST_MUL_P;
          end
        end
      end
      pidfd_pkg::ST_MUL_P: begin
        mul_a = 48'(err_r);
        mul_b = 33'(gain_p_r);
        if (!launched_r) begin
          mreq.go = 1'b1;
          launched_nxt = 1'b1;
        end else if (mul_done) begin
          p_nxt = mul_res;
          launched_nxt = 1'b0;
          state_nxt = pidfd_pkg::ST_MUL_I;
        end
      end
      pidfd_pkg::ST_MUL_I: begin
        mul_a = 48'(err_r);
        mul_b = 33'(gain_i_r);
        if (!launched_r) begin
          mreq.go = 1'b1;
          launched_nxt = 1'b1;
        end else if (mul_done) begin
          ip_nxt = mul_res;
          launched_nxt = 1'b0;
          state_nxt = pidfd_pkg::ST_MUL_IT;
        end
      end
      pidfd_pkg::ST_MUL_IT: begin
        mul_a = ip_r;
        mul_b = {1'b0, dt_r};
        mreq.shift_long = 1'b1;
        if (!launched_r) begin
          mreq.go = 1'b1;
          launched_nxt = 1'b1;
        end else if (mul_done) begin
          integ_nxt = 48'(pidfd_pkg::clamp_mag(50'(isum), int_bnd_r));
          launched_nxt = 1'b0;
          state_nxt = pidfd_pkg::ST_DIV;
        end
      end
      pidfd_pkg::ST_DIV: begin
        if (!launched_r) begin
          div_go = 1'b1;
          launched_nxt = 1'b1;
        end else if (div_done) begin
          rate_nxt = div_res;
          last_nxt = sensed_r;
          launched_nxt = 1'b0;
          state_nxt = pidfd_pkg::ST_MUL_F;
        end
      end
      pidfd_pkg::ST_MUL_F: begin
        mul_a = fdiff;
        mul_b = {16'd0, alpha_eff};
        if (!launched_r) begin
          mreq.go = 1'b1;
          launched_nxt = 1'b1;
        end else if (mul_done) begin
          frate_nxt = pidfd_pkg::sat48(50'(frate_r) + 50'(mul_res));
          launched_nxt = 1'b0;
          state_nxt = pidfd_pkg::ST_MUL_D;
        end
      end
      pidfd_pkg::ST_MUL_D: begin
        mul_a = frate_r;
        mul_b = 33'(gain_d_r);
        if (!launched_r) begin
          mreq.go = 1'b1;
          launched_nxt = 1'b1;
        end else if (mul_done) begin
          d_nxt = mul_res;
          launched_nxt = 1'b0;
          state_nxt = pidfd_pkg::ST_SUM;
        end
      end
      pidfd_pkg::ST_SUM: begin
        if (sum_cl > 50'sd2147483647) begin
          res_nxt = 32'sh7FFF_FFFF;
        end else if (sum_cl < -50'sd2147483648) begin
          res_nxt = 32'sh8000_0000;
        end else begin
          res_nxt = sum_cl[31:0];
        end
        state_nxt = pidfd_pkg::ST_DONE;
      end
      pidfd_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = pidfd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pidfd_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state, controller state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pidfd_pkg::ST_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      integ_r     <= 48'sd0;
      frate_r     <= 48'sd0;
      last_r      <= 32'sd0;
      gain_p_r    <= 32'sd0;
      gain_i_r    <= 32'sd0;
      gain_d_r    <= 32'sd0;
      int_bnd_r   <= 31'd0;
      out_bnd_r   <= 31'd0;
      alpha_r     <= pidfd_pkg::ALPHA_ONE;
    end else begin
      state_r     <= state_nxt;
      launched_r  <= launched_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      frate_r     <= frate_nxt;
      last_r      <= last_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          pidfd_pkg::REG_GAIN_P:  gain_p_r  <= cfg_data;
          pidfd_pkg::REG_GAIN_I:  gain_i_r  <= cfg_data;
          pidfd_pkg::REG_GAIN_D:  gain_d_r  <= cfg_data;
          pidfd_pkg::REG_INT_BND: int_bnd_r <= cfg_data[30:0];
          pidfd_pkg::REG_OUT_BND: out_bnd_r <= cfg_data[30:0];
          pidfd_pkg::REG_ALPHA:   alpha_r   <= cfg_data[16:0];
          default: ;
        endcase
      end
    end
    err_r      <= err_nxt;
    diff_r     <= diff_nxt;
    sensed_r   <= sensed_nxt;
    dt_r       <= dt_nxt;
    p_r        <= p_nxt;
    ip_r       <= ip_nxt;
    rate_r     <= rate_nxt;
    d_r        <= d_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

FILE: tb/tb_pid_controller_filtered_derivative_core.sv
// Self-checking testbench for the PID core with filtered derivative on measurement.
`default_nettype none
module tb_pid_controller_filtered_derivative_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        func;
    logic [31:0] target;
    logic [31:0] sensed;
    logic [31:0] step_time;
  } pid_item_t;

  localparam longint SAT_POS = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_NEG = -64'sh0000_8000_0000_0000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // target[31:0], sensed[63:32], step_time[95:64]
  logic        in_tuser;   // func
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // drive[31:0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  pid_controller_filtered_derivative_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Mirror of the controller's configuration and state.
  longint kp, ki, kd, int_limit, out_limit, alpha_eff;
  longint integ_acc, rate_filt, prev_sensed;

  pid_item_t   pending_items[$];
  logic [31:0] drive_expected[$];
  int          mismatches;
  int          results_seen;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Magnitude back to a signed value, saturated to 48 bits.
  function automatic longint from_mag(input bit neg, input logic [127:0] m);
    if (neg) begin
      if (m >= (128'd1 << 47)) return SAT_NEG;
      return -longint'(m[63:0]);
    end
    if (m > 128'h7FFF_FFFF_FFFF) return SAT_POS;
    return longint'(m[63:0]);
  endfunction

  // Product scaled down by 2^sh, truncated toward zero, saturated to 48 bits.
  function automatic longint fx_mul(input longint a, input longint b, input int sh);
    logic [127:0] ma, mb;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    return from_mag(neg, (ma * mb) >> sh);
  endfunction

  function automatic longint sat_48(input longint v);
    if (v > SAT_POS) return SAT_POS;
    if (v < SAT_NEG) return SAT_NEG;
    return v;
  endfunction

  function automatic longint limit_mag(input longint v, input longint bound);
    if (bound == 0) return v;
    if (v > bound) return bound;
    if (v < -bound) return -bound;
    return v;
  endfunction

  // Work out the drive for one accepted item and advance the state.
  function automatic logic [31:0] predict_drive(input pid_item_t it);
    longint err, p, ipart, diff, rate, d, sum, sens;
    logic [127:0] q;
    if (it.func == pidfd_pkg::FUNC_CLEAR) begin
      integ_acc = 0;
      rate_filt = 0;
      prev_sensed = 0;
      return 32'd0;
    end
    if (it.step_time == 32'd0) return 32'd0;
    sens = longint'($signed(it.sensed));
    err = longint'($signed(it.target)) - sens;
    p = fx_mul(err, kp, 16);
    ipart = fx_mul(fx_mul(err, ki, 16), longint'(it.step_time), 24);
    integ_acc = limit_mag(sat_48(integ_acc + ipart), int_limit);
    diff = prev_sensed - sens;
    q = ((diff < 0 ? 128'(-diff) : 128'(diff)) << 24) / it.step_time;
    rate = from_mag(diff < 0, q);
    diff = sat_48(rate - rate_filt);
    rate_filt = sat_48(rate_filt + fx_mul(diff, alpha_eff, 16));
    d = fx_mul(rate_filt, kd, 16);
    sum = limit_mag(p + integ_acc + d, out_limit);
    if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
    if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
    prev_sensed = sens;
    return sum[31:0];
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        drive_expected.push_back(predict_drive(pending_items.pop_front()));
      end
      if (in_tvalid && !in_tready) begin
        // Hold the beat until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {pending_items[0].step_time, pending_items[0].sensed,
                     pending_items[0].target};
        in_tuser <= pending_items[0].func;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern changing mode now and then, plus one long hold.
  int hold_left = 0;
  int mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (drive_expected.size() == 0) begin
          $error("drive: unexpected beat, actual %0d", $signed(out_tdata));
          mismatches++;
        end else begin
          logic [31:0] want;
          want = drive_expected.pop_front();
          if (want !== out_tdata) begin
            $error("drive: expected %0d, actual %0d", $signed(want), $signed(out_tdata));
            mismatches++;
          end
        end
        results_seen++;
        if (results_seen == 200) hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        mode_left--;
        if (mode_left <= 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 400);
        end
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Register write; the mirror is updated when the beat is taken.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pidfd_pkg::REG_GAIN_P:  kp = longint'($signed(val));
      pidfd_pkg::REG_GAIN_I:  ki = longint'($signed(val));
      pidfd_pkg::REG_GAIN_D:  kd = longint'($signed(val));
      pidfd_pkg::REG_INT_BND: int_limit = longint'(val[30:0]);
      pidfd_pkg::REG_OUT_BND: out_limit = longint'(val[30:0]);
      pidfd_pkg::REG_ALPHA:
        alpha_eff = (val[16:0] > pidfd_pkg::ALPHA_ONE) ? 65536 : longint'(val[16:0]);
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] gp, input logic [31:0] gi, input logic [31:0] gd,
                           input logic [31:0] ib, input logic [31:0] ob, input logic [31:0] al);
    write_reg(pidfd_pkg::REG_GAIN_P, gp);
    write_reg(pidfd_pkg::REG_GAIN_I, gi);
    write_reg(pidfd_pkg::REG_GAIN_D, gd);
    write_reg(pidfd_pkg::REG_INT_BND, ib);
    write_reg(pidfd_pkg::REG_OUT_BND, ob);
    write_reg(pidfd_pkg::REG_ALPHA, al);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_tvalid || drive_expected.size() > 0)
      @(posedge clk);
  endtask

  task automatic add_item(input logic f, input logic [31:0] t, input logic [31:0] s,
                          input logic [31:0] st);
    pid_item_t it;
    it.func = f;
    it.target = t;
    it.sensed = s;
    it.step_time = st;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom();
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_bound();
    case ($urandom_range(0, 5))
      0, 1: return 32'd0;
      2: return 32'd1;
      3: return 32'h7FFF_FFFF;
      4: return $urandom() & 32'h7FFF_FFFF;
      default: return $urandom_range(1, 32'h0100_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_alpha();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'd65536;
      2: return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  // Mostly plausible loop traffic, with clears, invalid steps and raw noise.
  task automatic add_random_item();
    int r;
    logic [31:0] t;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      add_item(pidfd_pkg::FUNC_CLEAR, $urandom(), $urandom(), $urandom());
    end else if (r < 7) begin
      add_item(pidfd_pkg::FUNC_UPDATE, $urandom(), $urandom(), 32'd0);
    end else if (r < 22) begin
      add_item(pidfd_pkg::FUNC_UPDATE, $urandom(), $urandom(), $urandom());
    end else begin
      t = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      add_item(pidfd_pkg::FUNC_UPDATE, t, t + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000,
               $urandom_range(1, 32'h0010_0000));
    end
  endtask

  // Stimulus and end of run.
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    kp = 0; ki = 0; kd = 0; int_limit = 0; out_limit = 0; alpha_eff = 65536;
    integ_acc = 0; rate_filt = 0; prev_sensed = 0;
    mismatches = 0;
    results_seen = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: default settings first, then plain gains with half filtering.
    add_item(pidfd_pkg::FUNC_UPDATE, 32'h0001_0000, 32'd0, 32'h0100_0000);
    wait_idle();
    write_all(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'd0, 32'd0, 32'h0000_8000);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'h0002_0000, 32'h0001_0000, 32'h0004_0000);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'h0001_0000, 32'h0000_0000, 32'd0);
    add_item(pidfd_pkg::FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    add_item(pidfd_pkg::FUNC_CLEAR, 32'd0, 32'd0, 32'd0);
    wait_idle();
    // Clamps engaged, gains at their extremes and filter coefficient above one.
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0002_0000,
              32'h0001_FFFF);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'h0010_0000, 32'hFFF0_0000, 32'h0100_0000);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'hFFF0_0000, 32'h0010_0000, 32'h0100_0000);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'd5, 32'd3, 32'd1);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'd0, 32'd0, 32'd0);
    wait_idle();
    write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'd0);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
    add_item(pidfd_pkg::FUNC_UPDATE, 32'h0000_1234, 32'hFFFF_0000, 32'h0000_0100);
    wait_idle();

    // Random phases with a fresh setting each.
    for (int ph = 0; ph < 8; ph++) begin
      write_all(rand_gain(), rand_gain(), rand_gain(), rand_bound(), rand_bound(),
                rand_alpha());
      if ($urandom_range(0, 1)) add_item(pidfd_pkg::FUNC_CLEAR, 32'd0, 32'd0, 32'd0);
      repeat (135) add_random_item();
      wait_idle();
    end

    repeat (300) @(posedge clk);
    if (mismatches == 0 && drive_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
